// ===== hdl/aksd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aksd_pkg;

   localparam int BYTE_W = 8;
   localparam int KEY_W  = 9;
   localparam int TEXT_W = 7;
   localparam int ACC_W  = 8;

   // Byte codes seen on the terminal link
   localparam logic [BYTE_W-1:0] CHR_BEL       = 8'd7;
   localparam logic [BYTE_W-1:0] CHR_ESC       = 8'd27;
   localparam logic [BYTE_W-1:0] CHR_LBRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHR_RBRACKET  = 8'h5D;
   localparam logic [BYTE_W-1:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHR_TILDE     = 8'h7E;
   localparam logic [BYTE_W-1:0] CHR_ZERO      = 8'h30;
   localparam logic [BYTE_W-1:0] CHR_NINE      = 8'h39;
   localparam logic [BYTE_W-1:0] CHR_A         = 8'h41;
   localparam logic [BYTE_W-1:0] CHR_B         = 8'h42;
   localparam logic [BYTE_W-1:0] CHR_C         = 8'h43;
   localparam logic [BYTE_W-1:0] CHR_D         = 8'h44;
   localparam logic [BYTE_W-1:0] CHR_F         = 8'h46;
   localparam logic [BYTE_W-1:0] CHR_H         = 8'h48;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_CTRL_C = 9'd3;
   localparam logic [KEY_W-1:0] KEY_CTRL_D = 9'd4;
   localparam logic [KEY_W-1:0] KEY_TAB    = 9'd9;
   localparam logic [KEY_W-1:0] KEY_ENTER  = 9'd13;
   localparam logic [KEY_W-1:0] KEY_CTRL_Z = 9'd26;
   localparam logic [KEY_W-1:0] KEY_ESC    = 9'd27;
   localparam logic [KEY_W-1:0] KEY_SPACE  = 9'd32;
   localparam logic [KEY_W-1:0] KEY_PRINT_MAX = 9'd126;
   localparam logic [KEY_W-1:0] KEY_BKSP   = 9'd127;
   localparam logic [KEY_W-1:0] KEY_UP     = 9'd256;
   localparam logic [KEY_W-1:0] KEY_DN     = 9'd257;
   localparam logic [KEY_W-1:0] KEY_RIGHT  = 9'd258;
   localparam logic [KEY_W-1:0] KEY_LEFT   = 9'd259;
   localparam logic [KEY_W-1:0] KEY_DELETE = 9'd260;
   localparam logic [KEY_W-1:0] KEY_HOME   = 9'd261;
   localparam logic [KEY_W-1:0] KEY_END    = 9'd262;
   localparam logic [KEY_W-1:0] KEY_PGUP   = 9'd263;
   localparam logic [KEY_W-1:0] KEY_PGDN   = 9'd264;
   localparam logic [KEY_W-1:0] KEY_INSERT = 9'd265;
   localparam logic [KEY_W-1:0] KEY_F1     = 9'd266;

   localparam logic [TEXT_W-1:0] TEXT_NEWLINE = 7'd10;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_INPUT_ENABLE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ESC,
      ST_CSI,
      ST_DIGITS,
      ST_OSC,
      ST_OSC_ESC
   } parse_state_type;

   typedef struct packed {
      parse_state_type      st;
      logic [ACC_W-1:0]     accum;
   } parser_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  code;
   } key_event_type;

   typedef struct packed {
      logic              emit;
      logic [KEY_W-1:0]  key_code;
      logic              has_text;
      logic [TEXT_W-1:0] text_char;
   } key_result_type;

   // Map the number in front of a tilde to a key
   function automatic key_event_type tilde_key(input logic [ACC_W-1:0] n);
      key_event_type k;
      k.valid = 1'b1;
      unique case (n)
         8'd1, 8'd7: k.code = KEY_HOME;
         8'd4, 8'd8: k.code = KEY_END;
         8'd2:  k.code = KEY_INSERT;
         8'd3:  k.code = KEY_DELETE;
         8'd5:  k.code = KEY_PGUP;
         8'd6:  k.code = KEY_PGDN;
         8'd11: k.code = KEY_F1;
         8'd12: k.code = KEY_F1 + 9'd1;
         8'd13: k.code = KEY_F1 + 9'd2;
         8'd14: k.code = KEY_F1 + 9'd3;
         8'd15: k.code = KEY_F1 + 9'd4;
         8'd17: k.code = KEY_F1 + 9'd5;
         8'd18: k.code = KEY_F1 + 9'd6;
         8'd19: k.code = KEY_F1 + 9'd7;
         8'd20: k.code = KEY_F1 + 9'd8;
         8'd21: k.code = KEY_F1 + 9'd9;
         8'd23: k.code = KEY_F1 + 9'd10;
         8'd24: k.code = KEY_F1 + 9'd11;
         default: begin
            k.valid = 1'b0;
            k.code  = '0;
         end
      endcase
      return k;
   endfunction

   // Keep only keys in the deliverable set and attach their text
   function automatic key_result_type filter_key(input key_event_type k);
      key_result_type r;
      r.emit      = 1'b0;
      r.key_code  = k.code;
      r.has_text  = 1'b0;
      r.text_char = '0;
      if (k.valid) begin
         priority if (k.code >= KEY_SPACE && k.code <= KEY_PRINT_MAX) begin
            r.emit      = 1'b1;
            r.has_text  = 1'b1;
            r.text_char = k.code[TEXT_W-1:0];
         end else if (k.code == KEY_TAB) begin
            r.emit      = 1'b1;
            r.has_text  = 1'b1;
            r.text_char = k.code[TEXT_W-1:0];
         end else if (k.code == KEY_ENTER) begin
            r.emit      = 1'b1;
            r.has_text  = 1'b1;
            r.text_char = TEXT_NEWLINE;
         end else if (k.code >= KEY_UP && k.code <= KEY_INSERT) begin
            r.emit = 1'b1;
         end else if (k.code == KEY_BKSP || k.code == KEY_ESC || k.code == KEY_CTRL_C ||
                      k.code == KEY_CTRL_D || k.code == KEY_CTRL_Z) begin
            r.emit = 1'b1;
         end else begin
            r.emit = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/aksd_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aksd_decoder (
   input  aksd_pkg::parser_type                 cur,
   input  logic [aksd_pkg::BYTE_W-1:0]          rx_byte,
   input  logic                                 rx_empty,
   input  logic                                 enable,
   output aksd_pkg::parser_type                 nxt,
   output aksd_pkg::key_result_type             result
);

   aksd_pkg::key_event_type   key;
   aksd_pkg::parse_state_type st_next;
   logic [aksd_pkg::ACC_W-1:0] acc_next;
   logic                      is_digit;
   logic [3:0]                digit;
   logic [11:0]               acc_grow;

   assign is_digit = (rx_byte >= aksd_pkg::CHR_ZERO) && (rx_byte <= aksd_pkg::CHR_NINE);
   assign digit    = rx_byte[3:0];
   // accum * 10 + digit, saturated below
   assign acc_grow = ({4'b0, cur.accum} << 3) + ({4'b0, cur.accum} << 1) + {8'b0, digit};

   always_comb begin
      key      = '{valid: 1'b0, code: '0};
      st_next  = cur.st;
      acc_next = cur.accum;
      if (!enable) begin
         st_next = aksd_pkg::ST_IDLE;
      end else begin
         unique case (cur.st)
            aksd_pkg::ST_IDLE: begin
               if (!rx_empty) begin
                  if (rx_byte == aksd_pkg::CHR_ESC) begin
                     st_next = aksd_pkg::ST_ESC;
                  end else begin
                     key = '{valid: 1'b1, code: {1'b0, rx_byte}};
                  end
               end
            end
            aksd_pkg::ST_ESC: begin
               st_next = aksd_pkg::ST_IDLE;
               priority if (rx_empty) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_ESC};
               end else if (rx_byte == aksd_pkg::CHR_LBRACKET) begin
                  st_next = aksd_pkg::ST_CSI;
               end else if (rx_byte == aksd_pkg::CHR_RBRACKET) begin
                  st_next = aksd_pkg::ST_OSC;
               end else begin
                  st_next = aksd_pkg::ST_IDLE;
               end
            end
            aksd_pkg::ST_CSI: begin
               st_next = aksd_pkg::ST_IDLE;
               priority if (rx_empty) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_ESC};
               end else if (rx_byte == aksd_pkg::CHR_A) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_UP};
               end else if (rx_byte == aksd_pkg::CHR_B) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_DN};
               end else if (rx_byte == aksd_pkg::CHR_C) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_RIGHT};
               end else if (rx_byte == aksd_pkg::CHR_D) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_LEFT};
               end else if (rx_byte == aksd_pkg::CHR_H) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_HOME};
               end else if (rx_byte == aksd_pkg::CHR_F) begin
                  key = '{valid: 1'b1, code: aksd_pkg::KEY_END};
               end else if (is_digit) begin
                  acc_next = {4'b0, digit};
                  st_next  = aksd_pkg::ST_DIGITS;
               end else if (rx_byte == aksd_pkg::CHR_TILDE) begin
                  key = aksd_pkg::tilde_key('0);
               end else begin
                  st_next = aksd_pkg::ST_IDLE;
               end
            end
            aksd_pkg::ST_DIGITS: begin
               priority if (rx_empty) begin
                  key     = '{valid: 1'b1, code: aksd_pkg::KEY_ESC};
                  st_next = aksd_pkg::ST_IDLE;
               end else if (is_digit) begin
                  acc_next = (acc_grow > 12'd255) ? 8'd255 : acc_grow[aksd_pkg::ACC_W-1:0];
               end else begin
                  if (rx_byte == aksd_pkg::CHR_TILDE) begin
                     key = aksd_pkg::tilde_key(cur.accum);
                  end
                  st_next = aksd_pkg::ST_IDLE;
               end
            end
            aksd_pkg::ST_OSC: begin
               priority if (rx_empty || rx_byte == aksd_pkg::CHR_BEL) begin
                  st_next = aksd_pkg::ST_IDLE;
               end else if (rx_byte == aksd_pkg::CHR_ESC) begin
                  st_next = aksd_pkg::ST_OSC_ESC;
               end else begin
                  st_next = aksd_pkg::ST_OSC;
               end
            end
            aksd_pkg::ST_OSC_ESC: begin
               if (!rx_empty && rx_byte == aksd_pkg::CHR_BACKSLASH) begin
                  st_next = aksd_pkg::ST_IDLE;
               end else begin
                  st_next = aksd_pkg::ST_OSC;
               end
            end
            default: begin
               st_next = aksd_pkg::ST_IDLE;
            end
         endcase
      end
      // leaving a sequence always clears the number
      if (st_next == aksd_pkg::ST_IDLE) begin
         acc_next = '0;
      end
      nxt.st    = st_next;
      nxt.accum = acc_next;
      result    = aksd_pkg::filter_key(key);
   end

endmodule

`default_nettype wire

// ===== hdl/ansi_key_sequence_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                   Beat
// req       in         req_valid/ready, rx_byte, rx_empty      one terminal byte or empty marker
// rsp       out        rsp_valid/ready, key_code, has_text,    one decoded key
//                      text_char
// csr       in/out     APB: psel, penable, pwrite, paddr, ...  input_enable at byte addresses 0 to 3
//
// Take one req beat per cycle while req_ready is high; an accepted beat decodes from the input
// register in the next cycle and lands in the result register (rsp_valid) when that slot is free.
// Beats that decode to no key are dropped and never wait on rsp_ready.
// A stalled rsp only holds the input register when the waiting beat makes a key.
// Synchronous reset clears valid flags, the parser (idle, number zero) and input_enable.
module ansi_key_sequence_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // input byte channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [aksd_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic                              req_rx_empty,
   // key channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [aksd_pkg::KEY_W-1:0]        rsp_key_code,
   output logic                              rsp_has_text,
   output logic [aksd_pkg::TEXT_W-1:0]       rsp_text_char,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aksd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [aksd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [aksd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // Input register
   logic                          in_valid_ff, in_valid_in;
   logic [aksd_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_empty_ff;

   // Parser state
   aksd_pkg::parser_type          parser_ff;
   aksd_pkg::parser_type          parser_in;

   // Result register
   logic                          out_valid_ff, out_valid_in;
   logic [aksd_pkg::KEY_W-1:0]    out_key_ff;
   logic                          out_text_ff;
   logic [aksd_pkg::TEXT_W-1:0]   out_char_ff;

   logic                          enable_ff;

   aksd_pkg::key_result_type      dec_result;
   logic                          req_take;
   logic                          out_free;
   logic                          advance;
   logic                          csr_write;
   logic                          csr_hit;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == aksd_pkg::CSR_IDX_INPUT_ENABLE);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_hit ? {{(aksd_pkg::CSR_DATA_W-1){1'b0}}, enable_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write && csr_hit) begin
         enable_ff <= csr_pwdata[0];
      end
   end

   // ---------------------------------------------------------------- decode
   aksd_decoder u_decoder (
      .cur      (parser_ff),
      .rx_byte  (in_byte_ff),
      .rx_empty (in_empty_ff),
      .enable   (enable_ff),
      .nxt      (parser_in),
      .result   (dec_result)
   );

   // Advance the held beat when its key has a free slot, or when it makes no key at all
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!dec_result.emit || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && dec_result.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         parser_ff    <= '{st: aksd_pkg::ST_IDLE, accum: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            parser_ff <= parser_in;
         end
      end
   end

   // Payload: hold until replaced
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_rx_byte;
         in_empty_ff <= req_rx_empty;
      end
      if (advance && dec_result.emit) begin
         out_key_ff  <= dec_result.key_code;
         out_text_ff <= dec_result.has_text;
         out_char_ff <= dec_result.text_char;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_code  = out_key_ff;
   assign rsp_has_text  = out_text_ff;
   assign rsp_text_char = out_char_ff;

endmodule

`default_nettype wire

// ===== hdl/aksd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aksd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [aksd_pkg::KEY_W-1:0]        rsp_key_code,
   input  logic                              rsp_has_text,
   input  logic [aksd_pkg::TEXT_W-1:0]       rsp_text_char
);

   // Stalled key holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code) &&
      $stable(rsp_has_text) && $stable(rsp_text_char))
      else $error("rsp beat changed while stalled");

   // Text follows the key: same byte, or newline for enter
   a_text_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_text |->
      (rsp_key_code == {2'b0, rsp_text_char}) ||
      (rsp_key_code == aksd_pkg::KEY_ENTER && rsp_text_char == aksd_pkg::TEXT_NEWLINE))
      else $error("text_char does not match key_code");

   a_no_text_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_text |-> rsp_text_char == '0)
      else $error("text_char set without text");

   // Function keys never leave the block
   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code <= aksd_pkg::KEY_INSERT)
      else $error("key_code outside deliverable set");

   a_out_drains: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind ansi_key_sequence_decoder aksd_checker u_aksd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_key_code  (rsp_key_code),
   .rsp_has_text  (rsp_has_text),
   .rsp_text_char (rsp_text_char)
);

`default_nettype wire
